[design/control_sequence_screen_terminal_core_macros.svh]
// Assertion macros for the terminal core RTL.
// Depends on nothing; included by the modules that carry assertions.
`ifndef CONTROL_SEQUENCE_SCREEN_TERMINAL_CORE_MACROS_SVH
`define CONTROL_SEQUENCE_SCREEN_TERMINAL_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is active.
`define CSSC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is active.
`define CSSC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/cssc_pkg.sv]
// Shared types and constants of the terminal core.
// Depends on nothing; used by the cell, the controller and the top level.
`timescale 1ns / 1ps

package cssc_pkg;

    localparam int SCREEN_ROWS_DEF = 10;
    localparam int SCREEN_COLS_DEF = 10;

    localparam logic [7:0] CH_BLANK  = 8'h20;
    localparam logic [7:0] CH_CARET  = 8'h5E;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] DIGIT_MAX = 8'd9;

    localparam logic [7:0] CMD_BOL    = 8'h62; // b
    localparam logic [7:0] CMD_CLEAR  = 8'h63; // c
    localparam logic [7:0] CMD_DOWN   = 8'h64; // d
    localparam logic [7:0] CMD_ERASE  = 8'h65; // e
    localparam logic [7:0] CMD_HOME   = 8'h68; // h
    localparam logic [7:0] CMD_INSERT = 8'h69; // i
    localparam logic [7:0] CMD_LEFT   = 8'h6C; // l
    localparam logic [7:0] CMD_OVER   = 8'h6F; // o
    localparam logic [7:0] CMD_RIGHT  = 8'h72; // r
    localparam logic [7:0] CMD_UP     = 8'h75; // u

    localparam logic [1:0] REQ_FEED  = 2'd0;
    localparam logic [1:0] REQ_READ  = 2'd1;
    localparam logic [1:0] REQ_RESET = 2'd2;

    typedef enum logic [2:0] {
        OP_NOP,
        OP_WRITE,
        OP_INSERT,
        OP_ERASE,
        OP_CLEAR
    } cell_op_t;

    // Command broadcast from the controller to every column cell.
    typedef struct packed {
        cell_op_t    op;
        logic [3:0]  row;
        logic [3:0]  col;
        logic [7:0]  data;
    } cell_cmd_t;

endpackage

[design/control_sequence_screen_terminal_core.sv]
// Top level of the escape-sequence text terminal: controller plus a chain
// of column cells. Depends on cssc_pkg, cssc_ctrl and cssc_cell.
//
//  Channel | Handshake            | Payload
//  --------+----------------------+---------------------------------------------
//  input   | in_valid / in_stall  | req_type, data_byte, read_row, read_col
//  output  | out_valid / out_stall| cell_char, cursor_row, cursor_col, insert_on
//
// A transaction is registered at acceptance and executed in the execute step,
// which writes the result register. No new transaction is taken before the
// last one has executed; the single execute step sets that pace. Write, insert,
// erase and clear all finish in the execute step, since each column cell updates
// its own characters and takes its shifted character from its left neighbor.
// Reset is asynchronous and active low; it blanks the screen, homes the cursor
// and selects overwrite mode. While the result is stalled, a newly accepted
// transaction waits in the execute step and in_stall stays high until the
// result is taken.
`timescale 1ns / 1ps

module control_sequence_screen_terminal_core #(
    parameter int SCREEN_ROWS = cssc_pkg::SCREEN_ROWS_DEF,
    parameter int SCREEN_COLS = cssc_pkg::SCREEN_COLS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [1:0] req_type,
    input  logic [7:0] data_byte,
    input  logic [3:0] read_row,
    input  logic [3:0] read_col,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] cell_char,
    output logic [3:0] cursor_row,
    output logic [3:0] cursor_col,
    output logic       insert_on
);

    cssc_pkg::cell_cmd_t         cmd;
    logic [SCREEN_COLS-1:0][7:0] col_data;

    cssc_ctrl #(
        .SCREEN_ROWS (SCREEN_ROWS),
        .SCREEN_COLS (SCREEN_COLS)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .req_type   (req_type),
        .data_byte  (data_byte),
        .read_row   (read_row),
        .read_col   (read_col),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .cell_char  (cell_char),
        .cursor_row (cursor_row),
        .cursor_col (cursor_col),
        .insert_on  (insert_on),
        .cmd        (cmd),
        .col_data   (col_data)
    );

    // One cell per column. Each cell hands the character at the addressed row
    // to its right neighbor, which is what a row insert shifts in.
    for (genvar k = 0; k < SCREEN_COLS; k++)
    begin : g_col
        logic [7:0] left_data;

        if (k == 0)
        begin : g_first
            assign left_data = cssc_pkg::CH_BLANK;
        end
        else
        begin : g_rest
            assign left_data = col_data[k-1];
        end

        cssc_cell #(
            .SCREEN_ROWS (SCREEN_ROWS),
            .COL_INDEX   (k)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .cmd       (cmd),
            .left_data (left_data),
            .row_data  (col_data[k])
        );
    end

endmodule

[design/cssc_cell.sv]
// One screen column: holds every row of that column and passes the
// addressed character to its right neighbor. Depends on cssc_pkg.
`timescale 1ns / 1ps

module cssc_cell #(
    parameter int SCREEN_ROWS = cssc_pkg::SCREEN_ROWS_DEF,
    parameter int COL_INDEX   = 0
) (
    input  logic                clk,
    input  logic                rst_n,
    input  cssc_pkg::cell_cmd_t cmd,
    input  logic [7:0]          left_data,
    output logic [7:0]          row_data
);

    localparam int ROW_AW = (SCREEN_ROWS > 1) ? $clog2(SCREEN_ROWS) : 1;
    localparam logic [3:0] ROWS_L = 4'(SCREEN_ROWS);
    localparam logic [3:0] MY_COL = 4'(COL_INDEX);

    logic [7:0]        chars_reg [SCREEN_ROWS];
    logic              row_ok;
    logic [ROW_AW-1:0] row_idx;

    assign row_ok   = cmd.row < ROWS_L;
    assign row_idx  = cmd.row[ROW_AW-1:0];
    assign row_data = row_ok ? chars_reg[row_idx] : cssc_pkg::CH_BLANK;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < SCREEN_ROWS; r++)
            begin
                chars_reg[r] <= cssc_pkg::CH_BLANK;
            end
        end
        else
        begin
            unique case (cmd.op)
                cssc_pkg::OP_WRITE:
                begin
                    if (row_ok && cmd.col == MY_COL)
                    begin
                        chars_reg[row_idx] <= cmd.data;
                    end
                end
                cssc_pkg::OP_INSERT:
                begin
                    // The cursor column takes the new character; every
                    // column to its right takes its left neighbor's.
                    if (row_ok && cmd.col == MY_COL)
                    begin
                        chars_reg[row_idx] <= cmd.data;
                    end
                    else if (row_ok && cmd.col < MY_COL)
                    begin
                        chars_reg[row_idx] <= left_data;
                    end
                end
                cssc_pkg::OP_ERASE:
                begin
                    if (row_ok && cmd.col <= MY_COL)
                    begin
                        chars_reg[row_idx] <= cssc_pkg::CH_BLANK;
                    end
                end
                cssc_pkg::OP_CLEAR:
                begin
                    for (int r = 0; r < SCREEN_ROWS; r++)
                    begin
                        chars_reg[r] <= cssc_pkg::CH_BLANK;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

endmodule

[design/cssc_ctrl.sv]
// Request sequencer: decodes the byte stream, keeps cursor and mode state,
// drives the column cells and holds the result register. Depends on cssc_pkg and the macros header.
`timescale 1ns / 1ps

`include "control_sequence_screen_terminal_core_macros.svh"

module cssc_ctrl #(
    parameter int SCREEN_ROWS = cssc_pkg::SCREEN_ROWS_DEF,
    parameter int SCREEN_COLS = cssc_pkg::SCREEN_COLS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [1:0]                   req_type,
    input  logic [7:0]                   data_byte,
    input  logic [3:0]                   read_row,
    input  logic [3:0]                   read_col,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [7:0]                   cell_char,
    output logic [3:0]                   cursor_row,
    output logic [3:0]                   cursor_col,
    output logic                         insert_on,
    output cssc_pkg::cell_cmd_t          cmd,
    input  logic [SCREEN_COLS-1:0][7:0]  col_data
);

    localparam int COL_AW = (SCREEN_COLS > 1) ? $clog2(SCREEN_COLS) : 1;
    localparam logic [3:0] ROWS_L    = 4'(SCREEN_ROWS);
    localparam logic [3:0] COLS_L    = 4'(SCREEN_COLS);
    localparam logic [7:0] DIGIT_TOP = cssc_pkg::CH_ZERO + cssc_pkg::DIGIT_MAX;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } state_t;

    typedef enum logic [1:0] {
        PH_TEXT,
        PH_ESC,
        PH_DIGIT
    } phase_t;

    state_t     st_reg, st_next;
    phase_t     phase_reg, phase_next;
    logic [1:0] req_reg;
    logic [7:0] byte_reg;
    logic [3:0] rrow_reg;
    logic [3:0] rcol_reg;
    logic [3:0] row_reg, row_next;
    logic [3:0] col_reg, col_next;
    logic       ins_reg, ins_next;
    logic [3:0] pend_reg, pend_next;
    logic       out_valid_reg, out_valid_next;
    logic [7:0] cell_char_reg, cell_char_next;

    logic       accept;
    logic       exec_go;
    logic       is_digit;
    logic [3:0] digit_val;
    logic [3:0] row_cl;
    logic [3:0] col_cl;
    logic [7:0] digit_diff;
    logic       cursor_ok;
    logic       res_held;
    logic [8:0] cur_state;

    function automatic logic [3:0] clamp(input logic [3:0] v, input logic [3:0] lim);
        return (v >= lim) ? (lim - 4'd1) : v;
    endfunction

    assign in_stall   = (st_reg == ST_EXEC);
    assign accept     = in_valid && !in_stall;
    assign exec_go    = (st_reg == ST_EXEC) && (!out_valid_reg || !out_stall);

    assign out_valid  = out_valid_reg;
    assign cell_char  = cell_char_reg;
    assign cursor_row = row_reg;
    assign cursor_col = col_reg;
    assign insert_on  = ins_reg;

    assign digit_diff = byte_reg - cssc_pkg::CH_ZERO;
    assign digit_val  = digit_diff[3:0];
    assign is_digit   = (byte_reg >= cssc_pkg::CH_ZERO) && (byte_reg <= DIGIT_TOP);
    assign row_cl     = clamp(row_reg, ROWS_L);
    assign col_cl     = clamp(col_reg, COLS_L);

    assign cursor_ok  = (row_reg < ROWS_L) && (col_reg < COLS_L);
    assign res_held   = out_valid_reg && out_stall;
    assign cur_state  = {row_reg, col_reg, ins_reg};

    always_comb
    begin
        st_next        = st_reg;
        phase_next     = phase_reg;
        row_next       = row_reg;
        col_next       = col_reg;
        ins_next       = ins_reg;
        pend_next      = pend_reg;
        out_valid_next = out_valid_reg;
        cell_char_next = cell_char_reg;
        cmd.op         = cssc_pkg::OP_NOP;
        cmd.row        = rrow_reg;
        cmd.col        = col_cl;
        cmd.data       = byte_reg;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        if (accept)
        begin
            st_next = ST_EXEC;
        end

        if (exec_go)
        begin
            st_next        = ST_IDLE;
            out_valid_next = 1'b1;
            cell_char_next = 8'h00;

            unique case (req_reg)
                cssc_pkg::REQ_FEED:
                begin
                    // Any byte other than a caret, or an escaped caret, goes to the cursor cell.
                    if ((phase_reg == PH_TEXT && byte_reg != cssc_pkg::CH_CARET) ||
                        (phase_reg == PH_ESC && byte_reg == cssc_pkg::CH_CARET))
                    begin
                        phase_next = PH_TEXT;
                        cmd.op     = ins_reg ? cssc_pkg::OP_INSERT : cssc_pkg::OP_WRITE;
                        cmd.row    = row_cl;
                        cmd.col    = col_cl;
                        row_next   = row_cl;
                        col_next   = (col_cl + 4'd1 < COLS_L) ? col_cl + 4'd1 : col_cl;
                    end
                    else if (phase_reg == PH_TEXT)
                    begin
                        phase_next = PH_ESC;
                    end
                    else if (phase_reg == PH_ESC && is_digit)
                    begin
                        pend_next  = digit_val;
                        phase_next = PH_DIGIT;
                    end
                    else if (phase_reg == PH_ESC)
                    begin
                        phase_next = PH_TEXT;
                        unique case (byte_reg)
                            cssc_pkg::CMD_BOL:    col_next = 4'd0;
                            cssc_pkg::CMD_CLEAR:  cmd.op = cssc_pkg::OP_CLEAR;
                            cssc_pkg::CMD_DOWN:
                            begin
                                if (row_reg + 4'd1 < ROWS_L)
                                begin
                                    row_next = row_reg + 4'd1;
                                end
                            end
                            cssc_pkg::CMD_UP:
                            begin
                                if (row_reg != 4'd0)
                                begin
                                    row_next = row_reg - 4'd1;
                                end
                            end
                            cssc_pkg::CMD_LEFT:
                            begin
                                if (col_reg != 4'd0)
                                begin
                                    col_next = col_reg - 4'd1;
                                end
                            end
                            cssc_pkg::CMD_RIGHT:
                            begin
                                if (col_reg + 4'd1 < COLS_L)
                                begin
                                    col_next = col_reg + 4'd1;
                                end
                            end
                            cssc_pkg::CMD_ERASE:
                            begin
                                cmd.op  = cssc_pkg::OP_ERASE;
                                cmd.row = row_cl;
                                cmd.col = col_reg;
                            end
                            cssc_pkg::CMD_HOME:
                            begin
                                row_next = 4'd0;
                                col_next = 4'd0;
                            end
                            cssc_pkg::CMD_INSERT: ins_next = 1'b1;
                            cssc_pkg::CMD_OVER:   ins_next = 1'b0;
                            default:
                            begin
                            end
                        endcase
                    end
                    else
                    begin
                        // Second digit of a cursor sequence; anything else drops it.
                        phase_next = PH_TEXT;
                        if (is_digit)
                        begin
                            row_next = clamp(pend_reg, ROWS_L);
                            col_next = clamp(digit_val, COLS_L);
                        end
                    end
                end
                cssc_pkg::REQ_READ:
                begin
                    if (rrow_reg < ROWS_L && rcol_reg < COLS_L)
                    begin
                        cell_char_next = col_data[rcol_reg[COL_AW-1:0]];
                    end
                end
                cssc_pkg::REQ_RESET:
                begin
                    cmd.op     = cssc_pkg::OP_CLEAR;
                    row_next   = 4'd0;
                    col_next   = 4'd0;
                    ins_next   = 1'b0;
                    phase_next = PH_TEXT;
                    pend_next  = 4'd0;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg        <= ST_IDLE;
            phase_reg     <= PH_TEXT;
            row_reg       <= 4'd0;
            col_reg       <= 4'd0;
            ins_reg       <= 1'b0;
            pend_reg      <= 4'd0;
            out_valid_reg <= 1'b0;
            cell_char_reg <= 8'h00;
        end
        else
        begin
            st_reg        <= st_next;
            phase_reg     <= phase_next;
            row_reg       <= row_next;
            col_reg       <= col_next;
            ins_reg       <= ins_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
            cell_char_reg <= cell_char_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg  <= req_type;
            byte_reg <= data_byte;
            rrow_reg <= read_row;
            rcol_reg <= read_col;
        end
    end

    `CSSC_ASSERT_IMP(a_cursor_in_screen, clk, rst_n, out_valid_reg, cursor_ok, "cursor off screen")
    `CSSC_ASSERT_NEXT(a_exec_held, clk, rst_n, in_stall && res_held, in_stall, "request lost")
    `CSSC_ASSERT_NEXT(a_exec_result, clk, rst_n, exec_go, out_valid_reg, "no result produced")
    `CSSC_ASSERT_NEXT(a_state_held, clk, rst_n, res_held, $stable(cur_state), "cursor moved on stall")

endmodule

[tb/sv/tb_control_sequence_screen_terminal_core.sv]
// Self-checking testbench for the escape-sequence text terminal core.
// Depends on cssc_pkg and control_sequence_screen_terminal_core; it keeps a
// shadow screen and compares every result transaction with its prediction.
`timescale 1ns / 1ps

module tb_control_sequence_screen_terminal_core;

    // The request kind that the block leaves without effect.
    localparam logic [1:0] REQ_SPARE = 2'd3;

    localparam int RANDOM_ITEMS  = 700;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int TAIL_CYCLES   = 10;
    localparam int PRINT_CAP     = 40;

    // Command bytes that may follow a caret, used by the random sequences.
    localparam logic [7:0] CMD_LIST [10] = '{
        cssc_pkg::CMD_BOL, cssc_pkg::CMD_CLEAR, cssc_pkg::CMD_DOWN,
        cssc_pkg::CMD_ERASE, cssc_pkg::CMD_HOME, cssc_pkg::CMD_INSERT,
        cssc_pkg::CMD_LEFT, cssc_pkg::CMD_OVER, cssc_pkg::CMD_RIGHT,
        cssc_pkg::CMD_UP
    };

    // Where the shadow parser stands within a caret sequence.
    typedef enum logic [1:0] {
        ESC_TEXT,
        ESC_AFTER_CARET,
        ESC_AFTER_DIGIT
    } esc_phase_t;

    // Receiver behavior, picked anew by the stall process below.
    typedef enum int {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_RUNS
    } stall_mode_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data;
        logic [3:0] rrow;
        logic [3:0] rcol;
    } term_req_t;

    typedef struct packed {
        logic [7:0] cell_char;
        logic [3:0] cur_row;
        logic [3:0] cur_col;
        logic       ins_mode;
    } term_result_t;

    // One request transaction, optionally with a result typed in by hand.
    typedef struct packed {
        term_req_t    req;
        logic         known;
        term_result_t result;
    } stim_entry_t;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    logic [1:0] req_type;
    logic [7:0] data_byte;
    logic [3:0] read_row;
    logic [3:0] read_col;
    logic       out_valid;
    logic       out_stall;
    logic [7:0] cell_char;
    logic [3:0] cursor_row;
    logic [3:0] cursor_col;
    logic       insert_on;

    // Shadow copy of the terminal state, advanced once per accepted request.
    logic [7:0] shadow_cells [cssc_pkg::SCREEN_ROWS_DEF][cssc_pkg::SCREEN_COLS_DEF];
    logic [3:0] shadow_row;
    logic [3:0] shadow_col;
    logic       shadow_insert;
    esc_phase_t shadow_phase;
    logic [3:0] shadow_row_digit;

    term_result_t expected_results [$];
    stim_entry_t  stim_plan [$];

    int          error_count = 0;
    int          results_seen = 0;
    int          cycle_count = 0;
    int          burst_left = 0;
    int          mode_left = 0;
    stall_mode_t stall_mode = STALL_NONE;

    control_sequence_screen_terminal_core uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .req_type   (req_type),
        .data_byte  (data_byte),
        .read_row   (read_row),
        .read_col   (read_col),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .cell_char  (cell_char),
        .cursor_row (cursor_row),
        .cursor_col (cursor_col),
        .insert_on  (insert_on)
    );

    // Free-running 100 MHz clock.
    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Every mismatch goes through here; printing stops after a cap so that a
    // badly broken design cannot flood the log, but every one is counted.
    task automatic report_mismatch(input string msg);
        if (error_count < PRINT_CAP)
            $display("MISMATCH @%0t: %s", $realtime, msg);
        error_count++;
    endtask

    task automatic blank_shadow();
        foreach (shadow_cells[i, j])
            shadow_cells[i][j] = cssc_pkg::CH_BLANK;
    endtask

    task automatic shadow_reset();
        blank_shadow();
        shadow_row       = '0;
        shadow_col       = '0;
        shadow_insert    = 1'b0;
        shadow_phase     = ESC_TEXT;
        shadow_row_digit = '0;
    endtask

    // Writes one text character at the cursor. In insert mode the rest of the
    // row slides right and the rightmost character falls off. The cursor then
    // moves one column but never past the last column.
    task automatic put_char(input logic [7:0] ch);
        int r;
        int c;
        r = (shadow_row >= cssc_pkg::SCREEN_ROWS_DEF) ?
            cssc_pkg::SCREEN_ROWS_DEF - 1 : int'(shadow_row);
        c = (shadow_col >= cssc_pkg::SCREEN_COLS_DEF) ?
            cssc_pkg::SCREEN_COLS_DEF - 1 : int'(shadow_col);
        if (shadow_insert)
        begin
            for (int k = cssc_pkg::SCREEN_COLS_DEF - 1; k > c; k--)
                shadow_cells[r][k] = shadow_cells[r][k - 1];
        end
        shadow_cells[r][c] = ch;
        if (c + 1 < cssc_pkg::SCREEN_COLS_DEF)
            c++;
        shadow_row = 4'(r);
        shadow_col = 4'(c);
    endtask

    // Advances the shadow terminal by one request and returns the result that
    // the block must produce for it.
    task automatic screen_step(input term_req_t rq, output term_result_t res);
        logic [7:0] ch;
        logic       is_digit;
        res      = '0;
        ch       = rq.data;
        is_digit = (ch >= cssc_pkg::CH_ZERO) &&
                   (ch <= cssc_pkg::CH_ZERO + cssc_pkg::DIGIT_MAX);
        case (rq.kind)
            cssc_pkg::REQ_FEED:
            begin
                case (shadow_phase)
                    ESC_AFTER_CARET:
                    begin
                        if (ch == cssc_pkg::CH_CARET)
                        begin
                            shadow_phase = ESC_TEXT;
                            put_char(ch);
                        end
                        else if (is_digit)
                        begin
                            shadow_row_digit = 4'(ch - cssc_pkg::CH_ZERO);
                            shadow_phase     = ESC_AFTER_DIGIT;
                        end
                        else
                        begin
                            // Any command byte, known or not, ends the escape.
                            shadow_phase = ESC_TEXT;
                            case (ch)
                                cssc_pkg::CMD_BOL:    shadow_col = '0;
                                cssc_pkg::CMD_CLEAR:  blank_shadow();
                                cssc_pkg::CMD_DOWN:
                                    if (shadow_row + 1 < cssc_pkg::SCREEN_ROWS_DEF)
                                        shadow_row++;
                                cssc_pkg::CMD_UP:
                                    if (shadow_row > 0)
                                        shadow_row--;
                                cssc_pkg::CMD_LEFT:
                                    if (shadow_col > 0)
                                        shadow_col--;
                                cssc_pkg::CMD_RIGHT:
                                    if (shadow_col + 1 < cssc_pkg::SCREEN_COLS_DEF)
                                        shadow_col++;
                                cssc_pkg::CMD_ERASE:
                                    for (int k = shadow_col; k < cssc_pkg::SCREEN_COLS_DEF;
                                         k++)
                                        shadow_cells[shadow_row][k] = cssc_pkg::CH_BLANK;
                                cssc_pkg::CMD_HOME:
                                begin
                                    shadow_row = '0;
                                    shadow_col = '0;
                                end
                                cssc_pkg::CMD_INSERT: shadow_insert = 1'b1;
                                cssc_pkg::CMD_OVER:   shadow_insert = 1'b0;
                                default:    ;
                            endcase
                        end
                    end
                    ESC_AFTER_DIGIT:
                    begin
                        // A non-digit here cancels the sequence and is dropped.
                        shadow_phase = ESC_TEXT;
                        if (is_digit)
                        begin
                            shadow_row = (shadow_row_digit >= cssc_pkg::SCREEN_ROWS_DEF) ?
                                         4'(cssc_pkg::SCREEN_ROWS_DEF - 1) :
                                         shadow_row_digit;
                            shadow_col = (ch - cssc_pkg::CH_ZERO >=
                                          cssc_pkg::SCREEN_COLS_DEF) ?
                                         4'(cssc_pkg::SCREEN_COLS_DEF - 1) :
                                         4'(ch - cssc_pkg::CH_ZERO);
                        end
                    end
                    default:
                    begin
                        if (ch == cssc_pkg::CH_CARET)
                            shadow_phase = ESC_AFTER_CARET;
                        else
                            put_char(ch);
                    end
                endcase
            end
            cssc_pkg::REQ_READ:
            begin
                if (rq.rrow < cssc_pkg::SCREEN_ROWS_DEF &&
                    rq.rcol < cssc_pkg::SCREEN_COLS_DEF)
                    res.cell_char = shadow_cells[rq.rrow][rq.rcol];
            end
            cssc_pkg::REQ_RESET:
                shadow_reset();
            default: ;
        endcase
        res.cur_row  = shadow_row;
        res.cur_col  = shadow_col;
        res.ins_mode = shadow_insert;
    endtask

    function automatic stim_entry_t stim_row(
        input logic [1:0] kind,
        input logic [7:0] data,
        input logic [3:0] rr,
        input logic [3:0] rc,
        input logic       known = 1'b0,
        input logic [7:0] want_char = 8'h00,
        input logic [3:0] want_row = 4'd0,
        input logic [3:0] want_col = 4'd0,
        input logic       want_ins = 1'b0
    );
        stim_entry_t ent;
        ent.req    = '{kind, data, rr, rc};
        ent.known  = known;
        ent.result = '{want_char, want_row, want_col, want_ins};
        return ent;
    endfunction

    // A feed transaction whose unused read fields carry random bits.
    function automatic stim_entry_t feed_row(input logic [7:0] ch);
        return stim_row(cssc_pkg::REQ_FEED, ch, 4'($urandom_range(0, 15)),
                        4'($urandom_range(0, 15)));
    endfunction

    // A random text byte that is never a caret; mostly printable characters.
    function automatic logic [7:0] text_byte();
        logic [7:0] ch;
        if ($urandom_range(0, 7) == 0)
            ch = 8'($urandom_range(0, 255));
        else
            ch = 8'($urandom_range(8'h20, 8'h7E));
        return (ch == cssc_pkg::CH_CARET) ? 8'h61 : ch;
    endfunction

    // Drives one request transaction. Called at a falling edge; the sender
    // works in bursts and, when a burst runs out, may drop valid for a random
    // gap before the next one. The shadow model is advanced at the rising edge
    // where the transaction is accepted, and the task returns at the falling edge
    // after it.
    task automatic drive_entry(input stim_entry_t ent);
        term_result_t predicted;
        int           gap;
        if (burst_left == 0)
        begin
            burst_left = ($urandom_range(0, 2) == 0) ? $urandom_range(20, 60) :
                                                       $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
        in_valid  <= 1'b1;
        req_type  <= ent.req.kind;
        data_byte <= ent.req.data;
        read_row  <= ent.req.rrow;
        read_col  <= ent.req.rcol;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        screen_step(ent.req, predicted);
        expected_results.push_back(ent.known ? ent.result : predicted);
        @(negedge clk);
    endtask

    // The receiver picks a new stall behavior whenever its mode count runs out: no
    // stall at all, light or heavy random stall, or long regular stall runs.
    always @(negedge clk)
    begin
        if (mode_left == 0)
        begin
            stall_mode = stall_mode_t'($urandom_range(0, 3));
            mode_left  = $urandom_range(10, 60);
        end
        mode_left--;
        case (stall_mode)
            STALL_NONE:  out_stall <= 1'b0;
            STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
            STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
            default:     out_stall <= ((mode_left % 8) < 5);
        endcase
    end

    // Result checker: every accepted result transaction is compared field by
    // field with the oldest outstanding prediction.
    always @(posedge clk)
    begin
        term_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_results.size() == 0)
            begin
                report_mismatch($sformatf("result %0d arrived with nothing expected",
                                          results_seen));
            end
            else
            begin
                want = expected_results.pop_front();
                if (cell_char !== want.cell_char)
                    report_mismatch($sformatf("result %0d cell_char %h, expected %h",
                                              results_seen, cell_char, want.cell_char));
                if (cursor_row !== want.cur_row)
                    report_mismatch($sformatf("result %0d cursor_row %0d, expected %0d",
                                              results_seen, cursor_row, want.cur_row));
                if (cursor_col !== want.cur_col)
                    report_mismatch($sformatf("result %0d cursor_col %0d, expected %0d",
                                              results_seen, cursor_col, want.cur_col));
                if (insert_on !== want.ins_mode)
                    report_mismatch($sformatf("result %0d insert_on %b, expected %b",
                                              results_seen, insert_on, want.ins_mode));
            end
            results_seen++;
        end
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial
    begin
        stim_entry_t directed_rows [25];
        int          pick;
        logic [7:0]  ch;

        rst_n     = 1'b0;
        in_valid  = 1'b0;
        req_type  = cssc_pkg::REQ_FEED;
        data_byte = 8'h00;
        read_row  = 4'd0;
        read_col  = 4'd0;
        shadow_reset();

        // Directed table. Results are typed in where they follow directly
        // from reset or from an out-of-range or unused request; the others
        // are taken from the shadow model.
        directed_rows = '{
            // Fresh screen: the home cell is a space, cursor home, overwrite.
            stim_row(cssc_pkg::REQ_READ,  8'h00, 4'd0,  4'd0,  1'b1, cssc_pkg::CH_BLANK),
            // Reads outside the screen return zero.
            stim_row(cssc_pkg::REQ_READ,  8'h00, 4'd15, 4'd0,  1'b1, 8'h00),
            stim_row(cssc_pkg::REQ_READ,  8'hFF, 4'd0,  4'd15, 1'b1, 8'h00),
            // The spare request kind changes nothing.
            stim_row(REQ_SPARE,           8'hFF, 4'd15, 4'd15, 1'b1, 8'h00),
            // Text, one byte of it at the top of the byte range.
            stim_row(cssc_pkg::REQ_FEED,  8'h41, 4'd0,  4'd0),
            stim_row(cssc_pkg::REQ_FEED,  8'hFF, 4'd15, 4'd15),
            // A read in the middle of an escape must not end it.
            stim_row(cssc_pkg::REQ_FEED,  cssc_pkg::CH_CARET,   4'd0, 4'd0),
            stim_row(cssc_pkg::REQ_READ,  8'h00,                4'd0, 4'd0),
            stim_row(cssc_pkg::REQ_FEED,  cssc_pkg::CMD_INSERT, 4'd0, 4'd0),
            // Insert a zero byte at the cursor, shifting the row right.
            stim_row(cssc_pkg::REQ_FEED,  8'h00,                4'd0, 4'd0),
            // Cursor to the bottom-right corner, then text there stays put.
            stim_row(cssc_pkg::REQ_FEED,  cssc_pkg::CH_CARET,   4'd0, 4'd0),
            stim_row(cssc_pkg::REQ_FEED,  8'h39,                4'd0, 4'd0),
            stim_row(cssc_pkg::REQ_FEED,  8'h39,                4'd0, 4'd0),
            stim_row(cssc_pkg::REQ_FEED,  8'h7E,                4'd0, 4'd0),
            // A broken cursor sequence drops the offending byte.
            stim_row(cssc_pkg::REQ_FEED,  cssc_pkg::CH_CARET,   4'd0, 4'd0),
            stim_row(cssc_pkg::REQ_FEED,  8'h34,                4'd0, 4'd0),
            stim_row(cssc_pkg::REQ_FEED,  8'h71,                4'd0, 4'd0),
            // An unknown command is ignored.
            stim_row(cssc_pkg::REQ_FEED,  cssc_pkg::CH_CARET,   4'd0, 4'd0),
            stim_row(cssc_pkg::REQ_FEED,  8'h7A,                4'd0, 4'd0),
            // A doubled caret prints one caret.
            stim_row(cssc_pkg::REQ_FEED,  cssc_pkg::CH_CARET,   4'd0, 4'd0),
            stim_row(cssc_pkg::REQ_FEED,  cssc_pkg::CH_CARET,   4'd0, 4'd0),
            // Erase to end of line from the last column.
            stim_row(cssc_pkg::REQ_FEED,  cssc_pkg::CH_CARET,   4'd0, 4'd0),
            stim_row(cssc_pkg::REQ_FEED,  cssc_pkg::CMD_ERASE,  4'd0, 4'd0),
            // A new screen homes the cursor and drops insert mode.
            stim_row(cssc_pkg::REQ_RESET, 8'h55, 4'd10, 4'd5,  1'b1, 8'h00),
            stim_row(cssc_pkg::REQ_READ,  8'h00, 4'd9,  4'd9,  1'b1, cssc_pkg::CH_BLANK)
        };

        // Hold reset, then release it away from the rising edge.
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed_rows[i])
            drive_entry(directed_rows[i]);

        // Random part. Most of it is well-formed text and caret sequences
        // with random content, so the cursor, insert mode and the screen get
        // exercised in depth; a smaller share is reads, broken sequences, unknown
        // commands, spare requests and the occasional new screen.
        while (stim_plan.size() < RANDOM_ITEMS)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 38)
            begin
                repeat ($urandom_range(1, 8))
                    stim_plan.push_back(feed_row(text_byte()));
            end
            else if (pick < 58)
            begin
                stim_plan.push_back(feed_row(cssc_pkg::CH_CARET));
                if ($urandom_range(0, 9) == 0)
                    stim_plan.push_back(stim_row(cssc_pkg::REQ_READ,
                                                 8'($urandom_range(0, 255)),
                                                 4'($urandom_range(0, 9)),
                                                 4'($urandom_range(0, 9))));
                // Clearing the whole screen is kept rare so text survives.
                ch = CMD_LIST[$urandom_range(0, 9)];
                if (ch == cssc_pkg::CMD_CLEAR && $urandom_range(0, 2) != 0)
                    ch = cssc_pkg::CMD_RIGHT;
                stim_plan.push_back(feed_row(ch));
            end
            else if (pick < 68)
            begin
                stim_plan.push_back(feed_row(cssc_pkg::CH_CARET));
                stim_plan.push_back(feed_row(cssc_pkg::CH_ZERO + 8'($urandom_range(0, 9))));
                if ($urandom_range(0, 7) == 0)
                    stim_plan.push_back(stim_row(cssc_pkg::REQ_READ,
                                                 8'($urandom_range(0, 255)),
                                                 4'($urandom_range(0, 15)),
                                                 4'($urandom_range(0, 15))));
                stim_plan.push_back(feed_row(cssc_pkg::CH_ZERO + 8'($urandom_range(0, 9))));
            end
            else if (pick < 82)
            begin
                stim_plan.push_back(stim_row(cssc_pkg::REQ_READ, 8'($urandom_range(0, 255)),
                    ($urandom_range(0, 5) == 0) ? 4'($urandom_range(0, 15)) :
                                                  4'($urandom_range(0, 9)),
                    ($urandom_range(0, 5) == 0) ? 4'($urandom_range(0, 15)) :
                                                  4'($urandom_range(0, 9))));
            end
            else if (pick < 87)
            begin
                stim_plan.push_back(feed_row(cssc_pkg::CH_CARET));
                stim_plan.push_back(feed_row(cssc_pkg::CH_CARET));
            end
            else if (pick < 91)
            begin
                // Broken cursor sequence: a digit followed by a non-digit.
                stim_plan.push_back(feed_row(cssc_pkg::CH_CARET));
                stim_plan.push_back(feed_row(cssc_pkg::CH_ZERO + 8'($urandom_range(0, 9))));
                ch = 8'($urandom_range(0, 255));
                if (ch >= cssc_pkg::CH_ZERO &&
                    ch <= cssc_pkg::CH_ZERO + cssc_pkg::DIGIT_MAX)
                    ch = 8'h78;
                stim_plan.push_back(feed_row(ch));
            end
            else if (pick < 96)
            begin
                // Caret followed by any byte at all.
                stim_plan.push_back(feed_row(cssc_pkg::CH_CARET));
                stim_plan.push_back(feed_row(8'($urandom_range(0, 255))));
            end
            else if (pick < 98)
            begin
                stim_plan.push_back(stim_row(REQ_SPARE, 8'($urandom_range(0, 255)),
                                             4'($urandom_range(0, 15)),
                                             4'($urandom_range(0, 15))));
            end
            else
            begin
                stim_plan.push_back(stim_row(cssc_pkg::REQ_RESET, 8'($urandom_range(0, 255)),
                                             4'($urandom_range(0, 15)),
                                             4'($urandom_range(0, 15))));
            end
        end

        foreach (stim_plan[i])
            drive_entry(stim_plan[i]);
        in_valid <= 1'b0;

        // Drain: wait for every predicted result, then keep the checker running over
        // a tail so that any stray result transaction is caught too.
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
